@@ src/ztss_pkg.sv @@
// ----------------------------------------------------------------------------
// ztss_pkg
// Shared types and codes for the zero-sum triplet search block.
// ----------------------------------------------------------------------------
package ztss_pkg;

    localparam int VALUE_W = 16;
    localparam int SUM_W   = 18;

    // input modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_FETCH  = 2'd2;
    // spare mode, answered as accepted with no effect
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_TRIPLET  = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] smallest;
        logic signed [VALUE_W-1:0] middle;
        logic signed [VALUE_W-1:0] largest;
    } out_word_t;

    typedef struct packed {
        logic eq_ab;
        logic a_gt_ref;
        logic sum_eq_ref;
        logic sum_lt_ref;
    } cmp_flags_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CMP,
        S_F_START,
        S_F_BOUND,
        S_F_BCHK,
        S_F_PAIR,
        S_F_PCHK,
        S_F_SKIPL,
        S_F_LCHK,
        S_F_SKIPR,
        S_F_RCHK,
        S_DONE
    } state_t;

endpackage

@@ src/ztss_store.sv @@
// ----------------------------------------------------------------------------
// ztss_store
// Sorted value store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module ztss_store #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [$clog2(STORE_DEPTH)-1:0]          wr_addr,
    input  logic signed [ztss_pkg::VALUE_W-1:0]     wr_data,
    input  logic [$clog2(STORE_DEPTH)-1:0]          rd_addr_a,
    input  logic [$clog2(STORE_DEPTH)-1:0]          rd_addr_b,
    output logic signed [ztss_pkg::VALUE_W-1:0]     rd_data_a,
    output logic signed [ztss_pkg::VALUE_W-1:0]     rd_data_b
);
    import ztss_pkg::*;

    logic signed [VALUE_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ src/ztss_unit.sv @@
// ----------------------------------------------------------------------------
// ztss_unit
// Shared add and compare unit used by every compare step of the sequencer.
// ----------------------------------------------------------------------------
module ztss_unit (
    input  logic signed [ztss_pkg::VALUE_W-1:0] op_a,
    input  logic signed [ztss_pkg::VALUE_W-1:0] op_b,
    input  logic signed [ztss_pkg::SUM_W-1:0]   ref_val,
    output ztss_pkg::cmp_flags_t                flags
);
    import ztss_pkg::*;

    logic signed [SUM_W-1:0] a_x;
    logic signed [SUM_W-1:0] b_x;
    logic signed [SUM_W-1:0] sum;

    assign a_x = {{(SUM_W-VALUE_W){op_a[VALUE_W-1]}}, op_a};
    assign b_x = {{(SUM_W-VALUE_W){op_b[VALUE_W-1]}}, op_b};
    assign sum = a_x + b_x;

    always_comb begin
        flags.eq_ab      = (op_a == op_b);
        flags.a_gt_ref   = (a_x > ref_val);
        flags.sum_eq_ref = (sum == ref_val);
        flags.sum_lt_ref = (sum < ref_val);
    end

endmodule

@@ src/ztss_seq.sv @@
// ----------------------------------------------------------------------------
// ztss_seq
// Sequencer: insertion into the sorted store and the resumable two-pointer
// walk, stepping the shared compare unit once per store read.
// ----------------------------------------------------------------------------
module ztss_seq #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  ztss_pkg::in_word_t                      in_word,
    output logic                                    res_valid,
    input  logic                                    res_ready,
    output ztss_pkg::out_word_t                     res_word,
    output logic                                    wr_en,
    output logic [$clog2(STORE_DEPTH)-1:0]          wr_addr,
    output logic signed [ztss_pkg::VALUE_W-1:0]     wr_data,
    output logic [$clog2(STORE_DEPTH)-1:0]          rd_addr_a,
    output logic [$clog2(STORE_DEPTH)-1:0]          rd_addr_b,
    input  logic signed [ztss_pkg::VALUE_W-1:0]     rd_data_a,
    input  logic signed [ztss_pkg::VALUE_W-1:0]     rd_data_b,
    output logic signed [ztss_pkg::SUM_W-1:0]       cmp_ref,
    input  ztss_pkg::cmp_flags_t                    flags
);
    import ztss_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CW-1:0] FIRST_BOUND = CW'(2);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           bound_reg, bound_next;
    logic [AW-1:0]           left_reg, left_next;
    logic [AW-1:0]           right_reg, right_next;
    logic                    started_reg, started_next;
    logic                    finished_reg, finished_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic signed [SUM_W-1:0] target_reg, target_next;
    out_word_t               res_reg, res_next;

    logic [CW-1:0]           bound_inc;
    logic                    left_lt_right;
    logic                    bound_done;
    logic                    bound_dup;
    logic                    store_full;
    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] value_ext;

    assign bound_inc     = bound_reg + 1'b1;
    assign left_lt_right = (left_reg < right_reg);
    assign bound_done    = finished_reg || (bound_reg >= count_reg);
    assign bound_dup     = (bound_inc < count_reg) && flags.eq_ab;
    assign store_full    = (count_reg == DEPTH_C);
    assign a_ext         = {{(SUM_W-VALUE_W){rd_data_a[VALUE_W-1]}}, rd_data_a};
    assign value_ext     = {{(SUM_W-VALUE_W){value_reg[VALUE_W-1]}}, value_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_word  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            bound_reg    <= FIRST_BOUND;
            left_reg     <= '0;
            right_reg    <= '0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            bound_reg    <= bound_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        target_reg <= target_next;
        res_reg    <= res_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (in_word.mode)
                        MODE_APPEND: state_next = store_full ? S_DONE : S_A_RD;
                        MODE_FETCH:  state_next = S_F_START;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_A_RD:    state_next = (pos_reg == '0) ? S_DONE : S_A_CMP;
            S_A_CMP:   state_next = flags.a_gt_ref ? S_A_RD : S_DONE;
            S_F_START: state_next = S_F_BOUND;
            S_F_BOUND: state_next = bound_done ? S_DONE : S_F_BCHK;
            S_F_BCHK:  state_next = bound_dup ? S_F_BOUND : S_F_PAIR;
            S_F_PAIR:  state_next = left_lt_right ? S_F_PCHK : S_F_BOUND;
            S_F_PCHK:  state_next = flags.sum_eq_ref ? S_F_SKIPL : S_F_PAIR;
            S_F_SKIPL: state_next = left_lt_right ? S_F_LCHK : S_F_SKIPR;
            S_F_LCHK:  state_next = flags.eq_ab ? S_F_SKIPL : S_F_SKIPR;
            S_F_SKIPR: state_next = left_lt_right ? S_F_RCHK : S_DONE;
            S_F_RCHK:  state_next = flags.eq_ab ? S_F_SKIPR : S_DONE;
            S_DONE:    state_next = res_ready ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and store access
    always_comb begin
        count_next    = count_reg;
        bound_next    = bound_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        target_next   = target_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = value_reg;
        rd_addr_a     = left_reg;
        rd_addr_b     = right_reg;
        cmp_ref       = target_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_next = '{status: ST_ACCEPTED, default: '0};
                    case (in_word.mode)
                        MODE_CLEAR: begin
                            count_next    = '0;
                            bound_next    = FIRST_BOUND;
                            left_next     = '0;
                            right_next    = '0;
                            started_next  = 1'b0;
                            finished_next = 1'b0;
                        end
                        MODE_APPEND: begin
                            if (store_full) begin
                                res_next = '{status: ST_FULL, default: '0};
                            end else begin
                                pos_next      = count_reg[AW-1:0];
                                value_next    = in_word.value;
                                bound_next    = FIRST_BOUND;
                                left_next     = '0;
                                right_next    = '0;
                                started_next  = 1'b0;
                                finished_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_A_RD: begin
                rd_addr_a = pos_reg - 1'b1;
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            S_A_CMP: begin
                cmp_ref = value_ext;
                wr_en   = 1'b1;
                if (flags.a_gt_ref) begin
                    // shift the larger word up one place
                    wr_data  = rd_data_a;
                    pos_next = pos_reg - 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            S_F_START: begin
                if (!started_reg) begin
                    started_next = 1'b1;
                    bound_next   = FIRST_BOUND;
                    left_next    = '0;
                    right_next   = AW'(1);
                end
            end
            S_F_BOUND: begin
                rd_addr_a = bound_reg[AW-1:0];
                rd_addr_b = bound_inc[AW-1:0];
                if (bound_done) begin
                    finished_next = 1'b1;
                    res_next      = '{status: ST_NONE, default: '0};
                end
            end
            S_F_BCHK: begin
                if (bound_dup) begin
                    // only the last copy of a value serves as largest member
                    bound_next = bound_inc;
                    left_next  = '0;
                    right_next = bound_reg[AW-1:0];
                end else begin
                    target_next      = -a_ext;
                    res_next.largest = rd_data_a;
                end
            end
            S_F_PAIR: begin
                if (!left_lt_right) begin
                    bound_next = bound_inc;
                    left_next  = '0;
                    right_next = bound_reg[AW-1:0];
                end
            end
            S_F_PCHK: begin
                if (flags.sum_eq_ref) begin
                    res_next.status   = ST_TRIPLET;
                    res_next.smallest = rd_data_a;
                    res_next.middle   = rd_data_b;
                    left_next         = left_reg + 1'b1;
                    right_next        = right_reg - 1'b1;
                end else if (flags.sum_lt_ref) begin
                    left_next = left_reg + 1'b1;
                end else begin
                    right_next = right_reg - 1'b1;
                end
            end
            S_F_SKIPL: begin
                rd_addr_b = left_reg - 1'b1;
            end
            S_F_LCHK: begin
                if (flags.eq_ab) begin
                    left_next = left_reg + 1'b1;
                end
            end
            S_F_SKIPR: begin
                rd_addr_a = right_reg;
                rd_addr_b = right_reg + 1'b1;
            end
            S_F_RCHK: begin
                if (flags.eq_ab) begin
                    right_next = right_reg - 1'b1;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ src/zero_sum_triplet_search.sv @@
// ----------------------------------------------------------------------------
// zero_sum_triplet_search
// Sorted store with insertion on append and a resumable two-pointer walk
// that returns the next distinct zero-sum triplet on each fetch.
//
//   port group   dir   handshake          payload
//   s_*          in    s_valid/s_ready    s_data  (mode, value)
//   m_*          out   m_valid/m_ready    m_data  (status, smallest, middle, largest)
//
// clear, mode 3 and a dropped append go straight to the result; an append
// shifts each larger word up one place until the new value lands (at the
// bottom at most); a fetch visits each bound (a repeated value is passed
// over), steps the two pointers inward and skips duplicates after a match;
// all steps share the store's two read ports and one compare unit.
// aresetn clears the count and the search state; the store itself is not
// cleared and only words below the count are used.
// a finished result waits in the output register while the next word is taken;
// the sequencer stalls at its end only while that register is full and not drained.
// ----------------------------------------------------------------------------
module zero_sum_triplet_search #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ztss_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ztss_pkg::out_word_t m_data
);
    import ztss_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic signed [VALUE_W-1:0] rd_data_a;
    logic signed [VALUE_W-1:0] rd_data_b;
    logic signed [SUM_W-1:0] cmp_ref;
    cmp_flags_t              flags;

    logic                    res_valid;
    logic                    res_ready;
    out_word_t               res_word;

    logic                    m_valid_reg, m_valid_next;
    out_word_t               m_data_reg, m_data_next;

    ztss_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    ztss_unit u_unit (
        .op_a    (rd_data_a),
        .op_b    (rd_data_b),
        .ref_val (cmp_ref),
        .flags   (flags)
    );

    ztss_seq #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .cmp_ref   (cmp_ref),
        .flags     (flags)
    );

    // output register frees when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
